[rtl/fskp_pkg.sv]
package fskp_pkg;

  localparam int MAX_HALF    = 8;
  localparam int MAX_LEN     = 1024;
  localparam int SAMPLE_BITS = 32;
  localparam int WIN_DEPTH   = 2 * MAX_HALF + 1;
  localparam int CNT_W       = $clog2(MAX_LEN + 1);
  localparam int IDX_W       = 10;
  localparam int K_W         = $clog2(MAX_HALF + 1);
  localparam int POS_W       = $clog2(WIN_DEPTH);
  localparam int HW_W        = 4;
  localparam int ADDR_W      = 3;

  localparam logic [ADDR_W-3:0] REG_HALF_WINDOW = '0;
  localparam logic [HW_W-1:0]   HALF_WINDOW_RST = HW_W'(1);

  typedef logic [SAMPLE_BITS-1:0] key_t;

  // signed sample to unsigned key with the same ordering
  function automatic key_t order_key(input logic [SAMPLE_BITS-1:0] raw);
    order_key = raw ^ {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  endfunction

endpackage

[rtl/fskp_cell.sv]
module fskp_cell (
  input  logic           clk_i,
  input  logic           shift_i,
  input  fskp_pkg::key_t din_i,
  input  fskp_pkg::key_t cand_i,
  output fskp_pkg::key_t dout_o,
  output logic           gt_o
);

  fskp_pkg::key_t val_q;
  fskp_pkg::key_t val_d;

  assign val_d = shift_i ? din_i : val_q;

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign dout_o = val_q;
  // candidate against the value this cell holds after the shift
  assign gt_o   = cand_i > din_i;

endmodule

[rtl/first_strict_k_peak_finder.sv]
// Strict k-peak finder over a stream of signed samples.
// Input channel: one beat per sample (sample_value_i, last_sample_i), taken
// when in_valid_i is high and in_stall_o low. The beat with last_sample_i
// set closes the array. Output channel: one beat per array, sent in the
// cycle after the closing sample is taken; peak_found_o flags a hit and
// peak_index_o holds the smallest index of a sample strictly above its k
// neighbors on each side (0 when none).
// Throughput: one sample per cycle while in_stall_o is low. The window is a
// row of 2*MAX_HALF+1 cells that shift each taken sample along while every
// cell compares its new value with the candidate in the same cycle.
// k is the half_window register at APB byte address 0 (reset value 1; 0
// acts as 1, values above 8 act as 8). Write it only while the block idles.
// After MAX_LEN samples in one array further samples are not tested.
// The result sits in an output register; while out_stall_i holds it, no
// new sample is taken.
// Reset clears the sample count, the latched hit, the output beat and
// restores half_window.
module first_strict_k_peak_finder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [31:0]             sample_value_i,
  input  logic                           last_sample_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           peak_found_o,
  output logic [fskp_pkg::IDX_W-1:0]     peak_index_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fskp_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int WD = fskp_pkg::WIN_DEPTH;

  logic [fskp_pkg::HW_W-1:0]  hw_q;
  logic [fskp_pkg::K_W-1:0]   k;
  logic                       cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = paddr[fskp_pkg::ADDR_W-1:2] == fskp_pkg::REG_HALF_WINDOW;
  assign prdata  = cfg_sel ? 32'(hw_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q <= fskp_pkg::HALF_WINDOW_RST;
    end else if (psel && penable && pwrite && cfg_sel) begin
      hw_q <= pwdata[fskp_pkg::HW_W-1:0];
    end
  end

  always_comb begin
    if (hw_q == '0) begin
      k = fskp_pkg::K_W'(1);
    end else if (32'(hw_q) > fskp_pkg::MAX_HALF) begin
      k = fskp_pkg::K_W'(fskp_pkg::MAX_HALF);
    end else begin
      k = fskp_pkg::K_W'(hw_q);
    end
  end

  logic [fskp_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                       hit_q, hit_d;
  logic [fskp_pkg::IDX_W-1:0] pos_q, pos_d;
  logic                       out_valid_q, out_valid_d;
  logic                       found_q;
  logic [fskp_pkg::IDX_W-1:0] index_q;

  logic in_acc, run, shift, test, all_gt;

  fskp_pkg::key_t        din   [WD];
  fskp_pkg::key_t        dout  [WD];
  fskp_pkg::key_t        cand;
  logic [WD-1:0]         gt;
  logic [WD-1:0]         active;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign run        = cnt_q < fskp_pkg::CNT_W'(fskp_pkg::MAX_LEN);
  assign shift      = in_acc & run;

  assign din[0] = fskp_pkg::order_key(sample_value_i);

  for (genvar j = 0; j < WD; j++) begin : g_cell
    if (j > 0) begin : g_link
      assign din[j] = dout[j-1];
    end
    fskp_cell u_cell (
      .clk_i  (clk_i),
      .shift_i(shift),
      .din_i  (din[j]),
      .cand_i (cand),
      .dout_o (dout[j]),
      .gt_o   (gt[j])
    );
    assign active[j] = (fskp_pkg::POS_W'(j) < fskp_pkg::POS_W'(k)) ||
                       ((fskp_pkg::POS_W'(j) > fskp_pkg::POS_W'(k)) &&
                        (fskp_pkg::POS_W'(j) <= {k, 1'b0}));
  end

  assign cand   = din[fskp_pkg::POS_W'(k)];
  assign all_gt = &(gt | ~active);
  assign test   = ~hit_q & (cnt_q >= fskp_pkg::CNT_W'({k, 1'b0})) & all_gt;

  always_comb begin
    hit_d = hit_q;
    pos_d = pos_q;
    cnt_d = cnt_q;
    if (shift) begin
      cnt_d = cnt_q + fskp_pkg::CNT_W'(1);
      if (test) begin
        hit_d = 1'b1;
        pos_d = fskp_pkg::IDX_W'(cnt_q - fskp_pkg::CNT_W'(k));
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q & out_stall_i;
    if (in_acc && last_sample_i) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      hit_q       <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_acc && last_sample_i) begin
        cnt_q <= '0;
        hit_q <= 1'b0;
        pos_q <= '0;
      end else begin
        cnt_q <= cnt_d;
        hit_q <= hit_d;
        pos_q <= pos_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && last_sample_i) begin
      found_q <= hit_d;
      index_q <= hit_d ? pos_d : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign peak_found_o = found_q;
  assign peak_index_o = index_q;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic                       found;
    logic [fskp_pkg::IDX_W-1:0] pos;
  } peak_result_t;

  localparam logic [fskp_pkg::ADDR_W-1:0] HALF_WINDOW_ADDR =
    {fskp_pkg::REG_HALF_WINDOW, 2'b00};

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic [31:0]                 sample_value_i = '0;
  logic                        last_sample_i = 1'b0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic                        peak_found_o;
  logic [fskp_pkg::IDX_W-1:0]  peak_index_o;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [fskp_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0]                 pwdata = '0;
  logic [31:0]                 prdata;
  logic                        pready;

  first_strict_k_peak_finder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_value_i(sample_value_i),
    .last_sample_i (last_sample_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .peak_found_o  (peak_found_o),
    .peak_index_o  (peak_index_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  int idle_pct  = 0;
  int stall_pct = 0;
  int mismatches = 0;

  always @(negedge clk_i) begin
    out_stall_i = ($urandom_range(99) < stall_pct);
  end

  // peak search model
  peak_result_t                pending_peaks[$];
  logic [31:0]                 win_keys[fskp_pkg::WIN_DEPTH];
  logic [fskp_pkg::CNT_W-1:0]  sample_cnt;
  logic                        hit_seen;
  logic [fskp_pkg::IDX_W-1:0]  hit_at;
  logic [fskp_pkg::HW_W-1:0]   half_window_model;

  task automatic clear_stream();
    sample_cnt = '0;
    hit_seen   = 1'b0;
    hit_at     = '0;
  endtask

  task automatic predict_sample(input logic [31:0] value, input logic last);
    int          k;
    logic [31:0] cand;
    bit          ok;
    peak_result_t res;
    k = (half_window_model == 0) ? 1 :
        (half_window_model > fskp_pkg::MAX_HALF) ? fskp_pkg::MAX_HALF :
        int'(half_window_model);
    if (sample_cnt < fskp_pkg::MAX_LEN) begin
      for (int i = fskp_pkg::WIN_DEPTH - 1; i > 0; i--) win_keys[i] = win_keys[i-1];
      win_keys[0] = value ^ 32'h8000_0000;
      if (!hit_seen && sample_cnt >= 2 * k) begin
        cand = win_keys[k];
        ok = 1'b1;
        for (int d = 0; d < k; d++) begin
          if (!(cand > win_keys[d]) || !(cand > win_keys[k+1+d])) ok = 1'b0;
        end
        if (ok) begin
          hit_seen = 1'b1;
          hit_at   = fskp_pkg::IDX_W'(sample_cnt - k);
        end
      end
      sample_cnt++;
    end
    if (last) begin
      res.found = hit_seen;
      res.pos   = hit_seen ? hit_at : '0;
      pending_peaks.push_back(res);
      clear_stream();
    end
  endtask

  always @(posedge clk_i) begin
    peak_result_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_peaks.size() == 0) begin
        $display("%0t: unexpected result beat found=%0d index=%0d",
                 $time, peak_found_o, peak_index_o);
        mismatches++;
      end else begin
        exp_res = pending_peaks.pop_front();
        if (peak_found_o !== exp_res.found) begin
          $display("%0t: peak_found expected %0d actual %0d",
                   $time, exp_res.found, peak_found_o);
          mismatches++;
        end
        if (peak_index_o !== exp_res.pos) begin
          $display("%0t: peak_index expected %0d actual %0d",
                   $time, exp_res.pos, peak_index_o);
          mismatches++;
        end
      end
    end
  end

  task automatic send_sample(input logic [31:0] value, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    sample_value_i = value;
    last_sample_i  = last;
    do @(posedge clk_i); while (in_stall_o);
    predict_sample(value, last);
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i = 1'b0;
    while (pending_peaks.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic apb_cycle(input bit wr, input logic [31:0] wdata,
                           output logic [31:0] rdata);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = HALF_WINDOW_ADDR;
    pwdata  = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // optional write, then read back against the model
  task automatic access_half_window(input bit wr,
                                    input logic [fskp_pkg::HW_W-1:0] value);
    logic [31:0] rdata;
    settle();
    if (wr) begin
      apb_cycle(1'b1, 32'(value), rdata);
      half_window_model = value;
    end
    apb_cycle(1'b0, '0, rdata);
    if (rdata[fskp_pkg::HW_W-1:0] !== half_window_model) begin
      $display("%0t: half_window expected %0d actual %0d",
               $time, half_window_model, rdata[fskp_pkg::HW_W-1:0]);
      mismatches++;
    end
  endtask

  function automatic logic [31:0] random_sample();
    int v;
    case ($urandom_range(9))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: begin
        v = int'($urandom_range(8)) - 4;
        return 32'(v);
      end
    endcase
  endfunction

  task automatic send_array(input int len);
    for (int i = 0; i < len; i++) send_sample(random_sample(), i == len - 1);
  endtask

  task automatic test_register_reset();
    access_half_window(1'b0, '0);
  endtask

  task automatic test_short_arrays();
    send_sample(32'd7, 1'b1);
    send_sample(32'hffff_fffd, 1'b0);
    send_sample(32'd9, 1'b1);
  endtask

  task automatic test_extremes();
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h7fff_ffff, 1'b0);
    send_sample(32'h8000_0000, 1'b1);
    send_sample(32'h7fff_ffff, 1'b0);
    send_sample(32'hffff_ffff, 1'b0);
    send_sample(32'h7fff_ffff, 1'b1);
  endtask

  task automatic test_half_window_clamp();
    access_half_window(1'b1, 4'd0);
    send_sample(32'd1, 1'b0);
    send_sample(32'd2, 1'b0);
    send_sample(32'd1, 1'b1);
    access_half_window(1'b1, 4'd15);
    send_sample(32'd0, 1'b0);
    send_sample(32'd1, 1'b0);
    send_sample(32'd9, 1'b0);
    send_sample(32'd1, 1'b0);
    send_sample(32'd0, 1'b1);
  endtask

  task automatic test_k_change_mid_array();
    access_half_window(1'b1, 4'd1);
    send_sample(32'd0, 1'b0);
    send_sample(32'd5, 1'b0);
    access_half_window(1'b1, 4'd2);
    send_sample(32'd1, 1'b0);
    send_sample(32'd0, 1'b1);
  endtask

  // count saturates: candidate at the limit and the later peak are not tested
  task automatic test_long_array();
    logic [31:0] v;
    access_half_window(1'b1, 4'd1);
    idle_pct  = 19;
    stall_pct = 19;
    for (int i = 0; i < 1030; i++) begin
      v = (i < 1023) ? 32'(i) : (i == 1023) ? 32'h7fff_ffff :
          (i == 1026) ? 32'd100 : 32'hffff_fffb;
      send_sample(v, i == 1029);
    end
  endtask

  task automatic test_random_arrays();
    int hw_plan[12] = '{1, 15, 0, 8, 3, 5, 2, 12, 7, 4, 6, 10};
    int sent;
    int len;
    for (int mode = 0; mode < 4; mode++) begin
      idle_pct  = (mode == 1) ? 72 : (mode == 3) ? 19 : 0;
      stall_pct = (mode == 2) ? 72 : (mode == 3) ? 19 : 0;
      for (int ph = 0; ph < 3; ph++) begin
        access_half_window(1'b1, fskp_pkg::HW_W'(hw_plan[mode*3+ph]));
        sent = 0;
        while (sent < 40) begin
          len = ($urandom_range(3) == 0) ? $urandom_range(1, 5) : $urandom_range(1, 40);
          send_array(len);
          sent += len;
        end
      end
    end
  endtask

  initial begin
    foreach (win_keys[i]) win_keys[i] = '0;
    clear_stream();
    half_window_model = fskp_pkg::HALF_WINDOW_RST;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_register_reset();
    test_short_arrays();
    test_extremes();
    test_half_window_clamp();
    test_k_change_mid_array();
    test_random_arrays();
    test_long_array();

    in_valid_i = 1'b0;
    while (pending_peaks.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
